// File: rtl/cdbl_pkg.sv
`timescale 1ns / 1ps

package cdbl_pkg;

    // Fixed field widths of the configuration registers
    localparam int GAIN_W       = 32;
    localparam int GAIN_FRAC    = 20;
    localparam int LIMIT_W      = 23;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Block-start threshold: clear output history when out1 * 2^16 < 2^(W-1)
    localparam int BLOCK_THR_SHIFT = 16;

    // Register reset values
    localparam logic [GAIN_W-1:0]  PRE_SCALE_RST  = 32'd134217728;
    localparam logic [LIMIT_W-1:0] CLIP_LIMIT_RST = 23'd1048576;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_PRE_SCALE  = 3'd0;
    localparam cfg_idx_t REG_CLIP_LIMIT = 3'd1;
    localparam cfg_idx_t REG_FILTER_ON  = 3'd2;
    localparam cfg_idx_t REG_B_MID      = 3'd3;
    localparam cfg_idx_t REG_A_ONE      = 3'd4;
    localparam cfg_idx_t REG_A_TWO      = 3'd5;

    // Microprogram address
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT      = 4'd0;
    localparam step_t STEP_MUL_GAIN  = 4'd1;
    localparam step_t STEP_CLIP      = 4'd2;
    localparam step_t STEP_TAPS      = 4'd3;
    localparam step_t STEP_MUL_B     = 4'd4;
    localparam step_t STEP_MUL_A1    = 4'd5;
    localparam step_t STEP_MUL_A2    = 4'd6;
    localparam step_t STEP_ACC_LAST  = 4'd7;
    localparam step_t STEP_EMIT_FILT = 4'd8;
    localparam step_t STEP_EMIT_CLIP = 4'd9;

    // Multiplier operand select
    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_GAIN = 3'd1,
        MUL_B    = 3'd2,
        MUL_A1   = 3'd3,
        MUL_A2   = 3'd4
    } mul_sel_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB2 = 2'd2
    } acc_op_t;

    // Datapath register operation
    typedef enum logic [2:0] {
        DP_NONE      = 3'd0,
        DP_TAKE      = 3'd1,
        DP_CLIP      = 3'd2,
        DP_TAPS      = 3'd3,
        DP_EMIT_FILT = 3'd4,
        DP_EMIT_CLIP = 3'd5
    } dp_op_t;

    // Sequencer branch kind
    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_WAIT_IN  = 2'd1,
        JMP_IF_OFF   = 2'd2,
        JMP_WAIT_OUT = 2'd3
    } jump_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        dp_op_t   op;
        jump_t    jump;
        step_t    target;
    } ctrl_t;

    // Control word plus execute strobe, sequencer to datapath
    typedef struct packed {
        ctrl_t word;
        logic  go;
    } seq_t;

    // Microcode ROM
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_NONE, jump: JMP_NEXT, target: STEP_WAIT};
        unique case (s)
            STEP_WAIT:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_TAKE,
                      jump: JMP_WAIT_IN, target: STEP_WAIT};
            STEP_MUL_GAIN:
                w = '{mul: MUL_GAIN, acc: ACC_HOLD, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_CLIP:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_CLIP,
                      jump: JMP_IF_OFF, target: STEP_EMIT_CLIP};
            STEP_TAPS:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_TAPS,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_MUL_B:
                w = '{mul: MUL_B, acc: ACC_HOLD, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_MUL_A1:
                w = '{mul: MUL_A1, acc: ACC_LOAD, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_MUL_A2:
                w = '{mul: MUL_A2, acc: ACC_SUB2, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_ACC_LAST:
                w = '{mul: MUL_NONE, acc: ACC_SUB2, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
            STEP_EMIT_FILT:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_EMIT_FILT,
                      jump: JMP_WAIT_OUT, target: STEP_WAIT};
            STEP_EMIT_CLIP:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_EMIT_CLIP,
                      jump: JMP_WAIT_OUT, target: STEP_WAIT};
            default:
                w = '{mul: MUL_NONE, acc: ACC_HOLD, op: DP_NONE,
                      jump: JMP_NEXT, target: STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/clip_distortion_biquad_lowpass.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    sample_in, block_start
// out       out_valid / out_ready  sample_out
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A microprogram of ten steps runs one request through a single shared multiplier.
// With the filter on, a request runs the gain product, clip, tap sum, three filter products,
// accumulate and emit steps; with it off, it runs the gain product, clip and emit steps.
// The output register holds a result until taken; the emit step waits only when it is full.
// Reset clears the filter history and loads the register defaults; cfg_ready is always high.
`timescale 1ns / 1ps

module clip_distortion_biquad_lowpass #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    input  logic                                   block_start,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic        [cdbl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [cdbl_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic        [cdbl_pkg::GAIN_W-1:0]  pre_scale_reg;
    logic        [cdbl_pkg::LIMIT_W-1:0] clip_limit_reg;
    logic                                filter_on_reg;
    logic signed [COEF_WIDTH-1:0]        b_mid_reg;
    logic signed [COEF_WIDTH-1:0]        a_one_reg;
    logic signed [COEF_WIDTH-1:0]        a_two_reg;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_free;
    logic                                emit_go;
    cdbl_pkg::seq_t                      seq;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_scale_reg  <= cdbl_pkg::PRE_SCALE_RST;
            clip_limit_reg <= cdbl_pkg::CLIP_LIMIT_RST;
            filter_on_reg  <= 1'b1;
            b_mid_reg      <= '0;
            a_one_reg      <= '0;
            a_two_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cdbl_pkg::REG_PRE_SCALE:  pre_scale_reg  <= cfg_data[cdbl_pkg::GAIN_W-1:0];
                cdbl_pkg::REG_CLIP_LIMIT: clip_limit_reg <= cfg_data[cdbl_pkg::LIMIT_W-1:0];
                cdbl_pkg::REG_FILTER_ON:  filter_on_reg  <= cfg_data[0];
                cdbl_pkg::REG_B_MID:      b_mid_reg      <= $signed(cfg_data[COEF_WIDTH-1:0]);
                cdbl_pkg::REG_A_ONE:      a_one_reg      <= $signed(cfg_data[COEF_WIDTH-1:0]);
                cdbl_pkg::REG_A_TWO:      a_two_reg      <= $signed(cfg_data[COEF_WIDTH-1:0]);
                default:                  ;
            endcase
        end
    end

    // Sequence the control words
    cdbl_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_free  (out_free),
        .filter_on (filter_on_reg),
        .seq       (seq)
    );

    // Run the arithmetic
    cdbl_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .seq         (seq),
        .sample_in   (sample_in),
        .block_start (block_start),
        .pre_scale   (pre_scale_reg),
        .clip_limit  (clip_limit_reg),
        .b_mid_coef  (b_mid_reg),
        .a_one_coef  (a_one_reg),
        .a_two_coef  (a_two_reg),
        .sample_out  (sample_out)
    );

    assign in_ready = (seq.word.jump == cdbl_pkg::JMP_WAIT_IN);
    assign emit_go  = seq.go && (seq.word.op == cdbl_pkg::DP_EMIT_FILT ||
                                 seq.word.op == cdbl_pkg::DP_EMIT_CLIP);
    assign out_free = !out_valid_reg || out_ready;

    // Hold the result until the output request is taken
    always_comb
    begin
        priority if (emit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // One request at a time: an accepted request drops ready in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after an accepted request");

    // A new result only comes from an emit step
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(emit_go))
        else $error("out_valid rose without an emit step");

    // Accepting and emitting never coincide
    a_no_accept_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready && emit_go))
        else $error("request accepted during an emit step");

endmodule

// File: rtl/cdbl_sequencer.sv
`timescale 1ns / 1ps

module cdbl_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          out_free,
    input  logic          filter_on,
    output cdbl_pkg::seq_t seq
);

    cdbl_pkg::step_t step_reg;
    cdbl_pkg::step_t step_next;
    cdbl_pkg::ctrl_t word;
    logic            go;

    // Fetch the control word
    assign word = cdbl_pkg::ucode(step_reg);

    // Stall on the wait steps until the handshake side is ready
    always_comb
    begin
        unique case (word.jump)
            cdbl_pkg::JMP_WAIT_IN:  go = in_valid;
            cdbl_pkg::JMP_WAIT_OUT: go = out_free;
            cdbl_pkg::JMP_NEXT,
            cdbl_pkg::JMP_IF_OFF:   go = 1'b1;
            default:                go = 1'b0;
        endcase
    end

    // Select the next step
    always_comb
    begin
        step_next = step_reg;
        if (go)
        begin
            unique case (word.jump)
                cdbl_pkg::JMP_NEXT,
                cdbl_pkg::JMP_WAIT_IN:  step_next = step_reg + 1'b1;
                cdbl_pkg::JMP_IF_OFF:   step_next = filter_on ? step_reg + 1'b1 : word.target;
                cdbl_pkg::JMP_WAIT_OUT: step_next = word.target;
                default:                step_next = cdbl_pkg::STEP_WAIT;
            endcase
        end
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cdbl_pkg::STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign seq.word = word;
    assign seq.go   = go;

endmodule

// File: rtl/cdbl_datapath.sv
`timescale 1ns / 1ps

module cdbl_datapath #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cdbl_pkg::seq_t                     seq,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
    input  logic                               block_start,
    input  logic        [cdbl_pkg::GAIN_W-1:0] pre_scale,
    input  logic       [cdbl_pkg::LIMIT_W-1:0] clip_limit,
    input  logic signed [COEF_WIDTH-1:0]       b_mid_coef,
    input  logic signed [COEF_WIDTH-1:0]       a_one_coef,
    input  logic signed [COEF_WIDTH-1:0]       a_two_coef,
    output logic signed [SAMPLE_WIDTH-1:0]     sample_out
);

    // Multiplier operand, product, tap sum, accumulator and threshold widths
    localparam int MA = (COEF_WIDTH > cdbl_pkg::GAIN_W) ? COEF_WIDTH : cdbl_pkg::GAIN_W + 1;
    localparam int TW = SAMPLE_WIDTH + 2;
    localparam int MB = TW;
    localparam int PW = MA + MB;
    localparam int AW = PW + 2;
    localparam int BW = SAMPLE_WIDTH + cdbl_pkg::BLOCK_THR_SHIFT;

    localparam logic signed [PW-1:0] GAIN_RND = PW'(1) << (cdbl_pkg::GAIN_FRAC - 1);
    localparam logic signed [PW-1:0] SMAX_P   = PW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [AW-1:0] SMAX_A   = AW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    localparam logic signed [AW-1:0] SMIN_A   = -SMAX_A - AW'(1);
    localparam logic signed [AW-1:0] ACC_RND  = AW'(1) << (COEF_WIDTH - 2);
    localparam logic signed [BW-1:0] BLK_THR  = BW'(1) << (SAMPLE_WIDTH - 1);

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] v_reg;
    logic signed [TW-1:0]           taps_reg;
    logic signed [PW-1:0]           prod_reg;
    logic signed [AW-1:0]           acc_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] in1_reg;
    logic signed [SAMPLE_WIDTH-1:0] in2_reg;
    logic signed [SAMPLE_WIDTH-1:0] out1_reg;
    logic signed [SAMPLE_WIDTH-1:0] out2_reg;

    logic signed [MA-1:0]           mul_a;
    logic signed [MB-1:0]           mul_b;
    logic signed [PW-1:0]           prod_next;
    logic signed [PW-1:0]           scaled;
    logic signed [PW-1:0]           lim_w;
    logic signed [PW-1:0]           clipped;
    logic signed [TW-1:0]           taps_next;
    logic signed [AW-1:0]           acc_next;
    logic signed [AW-1:0]           y_full;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic signed [BW-1:0]           out1_scaled;
    logic                           quiet;

    // Select multiplier operands
    always_comb
    begin
        unique case (seq.word.mul)
            cdbl_pkg::MUL_GAIN:
            begin
                mul_a = MA'($signed({1'b0, pre_scale}));
                mul_b = MB'(x_reg);
            end
            cdbl_pkg::MUL_B:
            begin
                mul_a = MA'(b_mid_coef);
                mul_b = taps_reg;
            end
            cdbl_pkg::MUL_A1:
            begin
                mul_a = MA'(a_one_coef);
                mul_b = MB'(out1_reg);
            end
            cdbl_pkg::MUL_A2:
            begin
                mul_a = MA'(a_two_coef);
                mul_b = MB'(out2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PW'(mul_a) * PW'(mul_b);

    // Round the gained sample and clamp it to the clip level
    assign scaled = (prod_reg + GAIN_RND) >>> cdbl_pkg::GAIN_FRAC;
    assign lim_w  = ($signed(PW'(clip_limit)) > SMAX_P) ? SMAX_P : $signed(PW'(clip_limit));

    always_comb
    begin
        priority if (scaled > lim_w)
            clipped = lim_w;
        else if (scaled < -lim_w)
            clipped = -lim_w;
        else
            clipped = scaled;
    end

    // Sum the feedforward taps: v + 2*in1 + in2
    assign taps_next = TW'(v_reg) + (TW'(in1_reg) <<< 1) + TW'(in2_reg);

    // Accumulate the products
    always_comb
    begin
        unique case (seq.word.acc)
            cdbl_pkg::ACC_LOAD: acc_next = AW'(prod_reg) + ACC_RND;
            cdbl_pkg::ACC_SUB2: acc_next = acc_reg - (AW'(prod_reg) <<< 1);
            default:            acc_next = acc_reg;
        endcase
    end

    // Scale and saturate the filter output
    assign y_full = acc_reg >>> (COEF_WIDTH - 1);

    always_comb
    begin
        priority if (y_full > SMAX_A)
            y_sat = SMAX_A[SAMPLE_WIDTH-1:0];
        else if (y_full < SMIN_A)
            y_sat = SMIN_A[SAMPLE_WIDTH-1:0];
        else
            y_sat = y_full[SAMPLE_WIDTH-1:0];
    end

    // Check the last output against the block-start threshold
    assign out1_scaled = $signed({out1_reg, {cdbl_pkg::BLOCK_THR_SHIFT{1'b0}}});
    assign quiet       = out1_scaled < BLK_THR;

    // Hold the working registers
    always_ff @(posedge clk)
    begin
        if (seq.go)
        begin
            if (seq.word.op == cdbl_pkg::DP_TAKE)
                x_reg <= sample_in;
            if (seq.word.mul != cdbl_pkg::MUL_NONE)
                prod_reg <= prod_next;
            if (seq.word.op == cdbl_pkg::DP_CLIP)
                v_reg <= clipped[SAMPLE_WIDTH-1:0];
            if (seq.word.op == cdbl_pkg::DP_TAPS)
                taps_reg <= taps_next;
            acc_reg <= acc_next;
            if (seq.word.op == cdbl_pkg::DP_EMIT_FILT)
                sample_out_reg <= y_sat;
            else if (seq.word.op == cdbl_pkg::DP_EMIT_CLIP)
                sample_out_reg <= v_reg;
        end
    end

    // Update the filter history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in1_reg  <= '0;
            in2_reg  <= '0;
            out1_reg <= '0;
            out2_reg <= '0;
        end
        else if (seq.go)
        begin
            if (seq.word.op == cdbl_pkg::DP_TAKE && block_start && quiet)
            begin
                out1_reg <= '0;
                out2_reg <= '0;
            end
            else if (seq.word.op == cdbl_pkg::DP_EMIT_FILT)
            begin
                in2_reg  <= in1_reg;
                in1_reg  <= v_reg;
                out2_reg <= out1_reg;
                out1_reg <= y_sat;
            end
        end
    end

    assign sample_out = sample_out_reg;

endmodule
